>>> sv/tia_pkg.sv
package tia_pkg;

    localparam logic [4:0] KIND_ADD  = 5'd0;
    localparam logic [4:0] KIND_SUB  = 5'd1;
    localparam logic [4:0] KIND_XOR  = 5'd2;
    localparam logic [4:0] KIND_OR   = 5'd3;
    localparam logic [4:0] KIND_AND  = 5'd4;
    localparam logic [4:0] KIND_SHL  = 5'd5;
    localparam logic [4:0] KIND_SHR  = 5'd6;
    localparam logic [4:0] KIND_SAR  = 5'd7;
    localparam logic [4:0] KIND_EQ   = 5'd8;
    localparam logic [4:0] KIND_NE   = 5'd9;
    localparam logic [4:0] KIND_LT   = 5'd10;
    localparam logic [4:0] KIND_GE   = 5'd11;
    localparam logic [4:0] KIND_LTU  = 5'd12;
    localparam logic [4:0] KIND_GEU  = 5'd13;
    localparam logic [4:0] KIND_NEG  = 5'd14;
    localparam logic [4:0] KIND_NOT  = 5'd15;
    localparam logic [4:0] KIND_CAST = 5'd16;

    localparam logic [2:0] TY_I1  = 3'd0;
    localparam logic [2:0] TY_I8  = 3'd1;
    localparam logic [2:0] TY_I16 = 3'd2;
    localparam logic [2:0] TY_I32 = 3'd3;
    localparam logic [2:0] TY_I64 = 3'd4;

    typedef struct packed {
        logic [4:0]  kind;
        logic [2:0]  result_type;
        logic [2:0]  source_type;
        logic        sign_cast;
        logic [63:0] left;
        logic [63:0] right;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] result;
        logic        invalid;
    } out_beat_t;

    // exec stage to normalize stage
    typedef struct packed {
        logic [63:0] raw;
        logic [2:0]  norm_type;
        logic        norm;
        logic        invalid;
    } raw_beat_t;

    function automatic logic [63:0] tia_sext(input logic [2:0] ty, input logic [63:0] v);
        case (ty)
            TY_I1:   return {63'd0, |v};
            TY_I8:   return {{56{v[7]}}, v[7:0]};
            TY_I16:  return {{48{v[15]}}, v[15:0]};
            TY_I32:  return {{32{v[31]}}, v[31:0]};
            default: return v;
        endcase
    endfunction

    function automatic logic [63:0] tia_zext(input logic [2:0] ty, input logic [63:0] v);
        case (ty)
            TY_I1:   return {63'd0, |v};
            TY_I8:   return {56'd0, v[7:0]};
            TY_I16:  return {48'd0, v[15:0]};
            TY_I32:  return {32'd0, v[31:0]};
            default: return v;
        endcase
    endfunction

endpackage

>>> sv/tia_exec.sv
module tia_exec
    import tia_pkg::*;
(
    input  logic      aclk,
    input  logic      load,
    input  in_beat_t  in_beat,
    output raw_beat_t raw_reg
);

    raw_beat_t  raw_next;
    logic [5:0] amt;
    logic [5:0] amt_mask;
    logic [63:0] l;
    logic [63:0] r;

    assign l = in_beat.left;
    assign r = in_beat.right;

    always_comb begin
        case (in_beat.result_type)
            TY_I1:   amt_mask = 6'd0;
            TY_I8:   amt_mask = 6'd7;
            TY_I16:  amt_mask = 6'd15;
            TY_I32:  amt_mask = 6'd31;
            default: amt_mask = 6'd63;
        endcase
    end

    assign amt = r[5:0] & amt_mask;

    always_comb begin
        raw_next.raw       = 64'd0;
        raw_next.norm_type = in_beat.result_type;
        raw_next.norm      = 1'b0;
        raw_next.invalid   = (in_beat.kind > KIND_CAST) || (in_beat.result_type > TY_I64)
                           || ((in_beat.kind == KIND_CAST) && (in_beat.source_type > TY_I64));
        case (in_beat.kind)
            KIND_ADD: begin
                raw_next.raw  = l + r;
                raw_next.norm = 1'b1;
            end
            KIND_SUB: begin
                raw_next.raw  = l - r;
                raw_next.norm = 1'b1;
            end
            KIND_XOR: raw_next.raw = l ^ r;
            KIND_OR:  raw_next.raw = l | r;
            KIND_AND: raw_next.raw = l & r;
            KIND_SHL: begin
                raw_next.raw  = l << amt;
                raw_next.norm = 1'b1;
            end
            KIND_SHR: begin
                raw_next.raw  = tia_zext(in_beat.result_type, l) >> amt;
                raw_next.norm = 1'b1;
            end
            KIND_SAR: raw_next.raw = $unsigned($signed(l) >>> amt);
            KIND_EQ:  raw_next.raw = {63'd0, l == r};
            KIND_NE:  raw_next.raw = {63'd0, l != r};
            KIND_LT:  raw_next.raw = {63'd0, $signed(l) < $signed(r)};
            KIND_GE:  raw_next.raw = {63'd0, $signed(l) >= $signed(r)};
            KIND_LTU: raw_next.raw = {63'd0, l < r};
            KIND_GEU: raw_next.raw = {63'd0, l >= r};
            KIND_NEG: begin
                raw_next.raw  = 64'd0 - l;
                raw_next.norm = 1'b1;
            end
            KIND_NOT: raw_next.raw = ~l;
            KIND_CAST: begin
                raw_next.raw  = in_beat.sign_cast ? tia_sext(in_beat.source_type, l)
                                                  : tia_zext(in_beat.source_type, l);
                raw_next.norm = 1'b1;
            end
            default: raw_next.raw = 64'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            raw_reg <= raw_next;
        end
    end

endmodule

>>> sv/tia_norm.sv
module tia_norm
    import tia_pkg::*;
(
    input  logic      aclk,
    input  logic      load,
    input  raw_beat_t raw_beat,
    output out_beat_t out_reg
);

    out_beat_t out_next;

    always_comb begin
        out_next.invalid = raw_beat.invalid;
        if (raw_beat.invalid) begin
            out_next.result = 64'd0;
        end else if (raw_beat.norm) begin
            out_next.result = tia_sext(raw_beat.norm_type, raw_beat.raw);
        end else begin
            out_next.result = raw_beat.raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= out_next;
        end
    end

endmodule

>>> sv/typed_ir_alu.sv
// Three register stages: input capture, execute, type normalize.
// An accepted beat moves a_data_reg, then b_data, then m_data (the m_ side).
// Throughput: one beat per cycle; a stall at m_ready backs up stage by stage.
// Reset (aresetn low, synchronous) clears the stage valid bits only.
module typed_ir_alu
    import tia_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic      a_valid_reg;
    logic      b_valid_reg;
    logic      c_valid_reg;
    in_beat_t  a_data_reg;
    raw_beat_t b_data;
    logic      ready_a;
    logic      ready_b;
    logic      ready_c;

    assign ready_c = !c_valid_reg || m_ready;
    assign ready_b = !b_valid_reg || ready_c;
    assign ready_a = !a_valid_reg || ready_b;
    assign s_ready = ready_a;
    assign m_valid = c_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (ready_a) begin
                a_valid_reg <= s_valid;
            end
            if (ready_b) begin
                b_valid_reg <= a_valid_reg;
            end
            if (ready_c) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_a) begin
            a_data_reg <= s_data;
        end
    end

    tia_exec u_exec (
        .aclk    (aclk),
        .load    (ready_b),
        .in_beat (a_data_reg),
        .raw_reg (b_data)
    );

    tia_norm u_norm (
        .aclk     (aclk),
        .load     (ready_c),
        .raw_beat (b_data),
        .out_reg  (m_data)
    );

`ifndef SYNTH
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.invalid |-> m_data.result == 64'd0)
        else $error("invalid beat carries nonzero result");

    a_full_on_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> a_valid_reg && b_valid_reg && c_valid_reg && !m_ready)
        else $error("input stalled while pipeline has room");

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> a_valid_reg)
        else $error("accepted beat lost at input stage");

    a_stage_b_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && ready_c |=> c_valid_reg)
        else $error("execute stage beat lost");
`endif

endmodule

>>> bench/tia_check_pkg.sv
package tia_check_pkg;

    import tia_pkg::*;

    function automatic int unsigned type_width(input logic [2:0] ty);
        case (ty)
            TY_I1:   return 1;
            TY_I8:   return 8;
            TY_I16:  return 16;
            TY_I32:  return 32;
            default: return 64;
        endcase
    endfunction

    // i1 collapses to 0/1, wider types keep their low bits and sign-fill
    function automatic logic [63:0] narrow_signed(input logic [2:0] ty, input logic [63:0] v);
        int unsigned sh;
        logic signed [63:0] t;
        if (ty == TY_I1) begin
            return {63'd0, |v};
        end
        sh = 64 - type_width(ty);
        t = v << sh;
        return t >>> sh;
    endfunction

    function automatic logic [63:0] narrow_unsigned(input logic [2:0] ty, input logic [63:0] v);
        int unsigned sh;
        if (ty == TY_I1) begin
            return {63'd0, |v};
        end
        sh = 64 - type_width(ty);
        return (v << sh) >> sh;
    endfunction

    function automatic out_beat_t compute_alu(input in_beat_t b);
        out_beat_t o;
        logic [63:0] l;
        logic [63:0] r;
        logic signed [63:0] sl;
        logic signed [63:0] sr;
        logic [5:0] amt;
        logic [2:0] rt;
        o.result = '0;
        o.invalid = 1'b0;
        if (b.kind > KIND_CAST || b.result_type > TY_I64
                || (b.kind == KIND_CAST && b.source_type > TY_I64)) begin
            o.invalid = 1'b1;
            return o;
        end
        l = b.left;
        r = b.right;
        sl = l;
        sr = r;
        rt = b.result_type;
        amt = b.right[5:0] & 6'(type_width(rt) - 1);
        case (b.kind)
            KIND_ADD:  o.result = narrow_signed(rt, l + r);
            KIND_SUB:  o.result = narrow_signed(rt, l - r);
            KIND_XOR:  o.result = l ^ r;
            KIND_OR:   o.result = l | r;
            KIND_AND:  o.result = l & r;
            KIND_SHL:  o.result = narrow_signed(rt, l << amt);
            KIND_SHR:  o.result = narrow_signed(rt, narrow_unsigned(rt, l) >> amt);
            KIND_SAR:  o.result = sl >>> amt;
            KIND_EQ:   o.result = {63'd0, l == r};
            KIND_NE:   o.result = {63'd0, l != r};
            KIND_LT:   o.result = {63'd0, sl < sr};
            KIND_GE:   o.result = {63'd0, !(sl < sr)};
            KIND_LTU:  o.result = {63'd0, l < r};
            KIND_GEU:  o.result = {63'd0, l >= r};
            KIND_NEG:  o.result = narrow_signed(rt, 64'd0 - l);
            KIND_NOT:  o.result = ~l;
            default: begin
                o.result = b.sign_cast ? narrow_signed(b.source_type, l)
                                       : narrow_unsigned(b.source_type, l);
                o.result = narrow_signed(rt, o.result);
            end
        endcase
        return o;
    endfunction

    class alu_scoreboard;
        out_beat_t pending_results[$];
        int unsigned fault_count;
        int unsigned beats_in;

        function new();
            fault_count = 0;
            beats_in = 0;
        endfunction

        function void note_input(input in_beat_t b);
            pending_results.push_back(compute_alu(b));
            beats_in++;
        endfunction

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            fault_count++;
        endtask

        task check_result(input out_beat_t got);
            out_beat_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected beat result=%h invalid=%b",
                                 got.result, got.invalid));
                return;
            end
            want = pending_results.pop_front();
            if (got.result !== want.result) begin
                report($sformatf("result got %h want %h", got.result, want.result));
            end
            if (got.invalid !== want.invalid) begin
                report($sformatf("invalid got %b want %b", got.invalid, want.invalid));
            end
        endtask
    endclass

endpackage

>>> bench/tb_typed_ir_alu.sv
module tb_typed_ir_alu
    import tia_pkg::*;
    import tia_check_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_BEATS = 650;
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned HOLD_CYCLES  = 400;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    alu_scoreboard sb;
    in_beat_t      stim_q[$];
    int unsigned   idle_cycles = 0;

    typed_ir_alu DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic in_beat_t make_beat(input logic [4:0] k, input logic [2:0] rt,
                                           input logic [2:0] st, input logic sc,
                                           input logic [63:0] l, input logic [63:0] r);
        in_beat_t b;
        b.kind = k;
        b.result_type = rt;
        b.source_type = st;
        b.sign_cast = sc;
        b.left = l;
        b.right = r;
        return b;
    endfunction

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h7FFF_FFFF_FFFF_FFFF;
            4:       return 64'($urandom_range(0, 80));
            5:       return narrow_signed(3'($urandom_range(0, 4)), w);
            default: return w;
        endcase
    endfunction

    function automatic in_beat_t random_beat();
        in_beat_t b;
        b.kind = ($urandom_range(0, 24) == 0) ? 5'($urandom_range(17, 31))
                                              : 5'($urandom_range(0, 16));
        b.result_type = ($urandom_range(0, 24) == 0) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4));
        if (b.kind == KIND_CAST) begin
            b.source_type = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                         : 3'($urandom_range(0, 4));
        end else begin
            b.source_type = 3'($urandom_range(0, 7));
        end
        b.sign_cast = 1'($urandom_range(0, 1));
        b.left = rand_word();
        case ($urandom_range(0, 5))
            0:       b.right = b.left;
            1:       b.right = b.left + 64'($urandom_range(0, 2)) - 64'd1;
            default: b.right = rand_word();
        endcase
        return b;
    endfunction

    task build_directed();
        stim_q.push_back(make_beat(KIND_ADD, TY_I64, TY_I1, 1'b0,
                                   64'h7FFF_FFFF_FFFF_FFFF, 64'd1));
        stim_q.push_back(make_beat(KIND_ADD, TY_I8, TY_I1, 1'b0, 64'h7F, 64'd1));
        stim_q.push_back(make_beat(KIND_ADD, TY_I1, TY_I1, 1'b0, 64'd1, 64'd1));
        stim_q.push_back(make_beat(KIND_SUB, TY_I16, TY_I1, 1'b0, 64'd0, 64'd1));
        stim_q.push_back(make_beat(KIND_XOR, TY_I8, TY_I1, 1'b0, '1,
                                   64'hA5A5_5A5A_0F0F_F0F0));
        stim_q.push_back(make_beat(KIND_OR, TY_I1, TY_I1, 1'b0,
                                   64'hFFFF_0000_FFFF_0000, 64'h0000_FFFF_0000_0001));
        stim_q.push_back(make_beat(KIND_AND, TY_I32, TY_I1, 1'b0, '1,
                                   64'h8000_0000_0000_0001));
        stim_q.push_back(make_beat(KIND_SHL, TY_I32, TY_I1, 1'b0, 64'd1, 64'd31));
        stim_q.push_back(make_beat(KIND_SHL, TY_I8, TY_I1, 1'b0, 64'd3, '1));
        stim_q.push_back(make_beat(KIND_SHR, TY_I8, TY_I1, 1'b0, 64'hFFFF_FFFF_FFFF_FF80,
                                   64'd1));
        stim_q.push_back(make_beat(KIND_SHR, TY_I64, TY_I1, 1'b0,
                                   64'h8000_0000_0000_0000, 64'd63));
        stim_q.push_back(make_beat(KIND_SAR, TY_I16, TY_I1, 1'b0,
                                   64'h8000_0000_0000_0000, 64'd15));
        stim_q.push_back(make_beat(KIND_SAR, TY_I1, TY_I1, 1'b0, '1, '1));
        stim_q.push_back(make_beat(KIND_EQ, TY_I64, TY_I1, 1'b0, '1, '1));
        stim_q.push_back(make_beat(KIND_NE, TY_I64, TY_I1, 1'b0, '1, '1));
        stim_q.push_back(make_beat(KIND_LT, TY_I64, TY_I1, 1'b0,
                                   64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF));
        stim_q.push_back(make_beat(KIND_GE, TY_I64, TY_I1, 1'b0,
                                   64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF));
        stim_q.push_back(make_beat(KIND_LTU, TY_I64, TY_I1, 1'b0,
                                   64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF));
        stim_q.push_back(make_beat(KIND_GEU, TY_I64, TY_I1, 1'b0, 64'd0, '1));
        stim_q.push_back(make_beat(KIND_NEG, TY_I64, TY_I1, 1'b0,
                                   64'h8000_0000_0000_0000, 64'd0));
        stim_q.push_back(make_beat(KIND_NEG, TY_I8, TY_I1, 1'b0, 64'hFFFF_FFFF_FFFF_FF80,
                                   64'd0));
        stim_q.push_back(make_beat(KIND_NOT, TY_I16, TY_I1, 1'b0, 64'd0, 64'd0));
        stim_q.push_back(make_beat(KIND_CAST, TY_I64, TY_I8, 1'b1, 64'h80, 64'd0));
        stim_q.push_back(make_beat(KIND_CAST, TY_I32, TY_I8, 1'b0, '1, 64'd0));
        stim_q.push_back(make_beat(KIND_CAST, TY_I1, TY_I64, 1'b1,
                                   64'h8000_0000_0000_0000, 64'd0));
        stim_q.push_back(make_beat(KIND_CAST, TY_I16, TY_I32, 1'b0, 64'h0001_8000, 64'd0));
        stim_q.push_back(make_beat(5'd31, TY_I64, TY_I1, 1'b0, '1, '1));
        stim_q.push_back(make_beat(KIND_ADD, 3'd7, TY_I1, 1'b0, 64'd1, 64'd1));
        stim_q.push_back(make_beat(KIND_CAST, TY_I64, 3'd5, 1'b1, '1, 64'd0));
        stim_q.push_back(make_beat(KIND_ADD, TY_I64, 3'd7, 1'b1, 64'd2, 64'd3));
    endtask

    task drive_beats();
        int unsigned burst_left;
        int unsigned gap;
        burst_left = 0;
        foreach (stim_q[i]) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 40);
            end
            s_valid <= 1'b1;
            s_data  <= stim_q[i];
            do @(posedge aclk); while (!s_ready);
            sb.note_input(stim_q[i]);
            burst_left--;
        end
        s_valid <= 1'b0;
    endtask

    // result channel: random stall patterns, plus one long hold to back up the pipe
    initial begin
        int unsigned mode;
        int unsigned span;
        bit held;
        held = 1'b0;
        @(posedge aclk);
        forever begin
            if (!held && sb.beats_in >= 150) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            repeat (span) begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        build_directed();
        repeat (RANDOM_BEATS) stim_q.push_back(random_beat());
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        drive_beats();
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.pending_results.size() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));
        end
        if (sb.fault_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
sv/tia_pkg.sv
sv/tia_exec.sv
sv/tia_norm.sv
sv/typed_ir_alu.sv
bench/tia_check_pkg.sv
bench/tb_typed_ir_alu.sv
